[src/assert_macros.svh]
// Assertion macros for the checker file mct_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define MCT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high.
`define MCT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/mct_pkg.sv]
// Shared types and constants of the markup character tokenizer.
// No dependencies; used by every module of the block.
`default_nettype none

package mct_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [3:0] {
    ST_SEARCH = 4'd0,
    ST_LT     = 4'd1,
    ST_NAME   = 4'd2,
    ST_INT    = 4'd3,
    ST_MINUS  = 4'd4,
    ST_SLASH  = 4'd5,
    ST_DEC    = 4'd6,
    ST_QUOTED = 4'd7,
    ST_BLANK  = 4'd8,
    ST_QUEST  = 4'd9,
    ST_COPEN  = 4'd10,
    ST_CCLOSE = 4'd11
  } lex_state_t;

  typedef enum logic [4:0] {
    K_LT     = 5'd0,
    K_GT     = 5'd1,
    K_EQ     = 5'd2,
    K_NAME   = 5'd3,
    K_INT    = 5'd4,
    K_MINUS  = 5'd5,
    K_SLASH  = 5'd6,
    K_DEC    = 5'd7,
    K_QUOTED = 5'd8,
    K_BLANK  = 5'd9,
    K_QUEST  = 5'd10,
    K_HOPEN  = 5'd11,
    K_HCLOSE = 5'd12,
    K_CLOPEN = 5'd13,
    K_ECLOSE = 5'd14,
    K_COPEN  = 5'd15,
    K_CCLOSE = 5'd16,
    K_ERROR  = 5'd17
  } kind_t;

  // One result: token character or end-of-token marker.
  typedef struct packed {
    logic       item_kind;
    logic [7:0] token_char;
    kind_t      token_kind;
  } res_t;

  // All results caused by one input item (cnt of them, 1 to 3).
  typedef struct packed {
    logic [1:0]     cnt;
    res_t [2:0]     res;
  } bundle_t;

  localparam logic ITEM_CHAR = 1'b0;
  localparam logic ITEM_END  = 1'b1;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;

endpackage

`default_nettype wire

[src/markup_char_tokenizer.sv]
// Top level of the markup character tokenizer.
// Depends on mct_pkg, mct_front, mct_queue and mct_back.
//
// Usage:
//  - Input channel (in_valid/in_ready): one text byte per transfer, or an
//    end_of_input marker that closes any partial token.
//  - Output channel (out_valid/out_ready): one result per transfer, either
//    a token character or an end-of-token item with the token's kind.
//    last_of_run flags the last result caused by one input transfer.
//  - Each input byte causes zero to three results.
//  - Results are written into the bundle queue on the input's transfer and
//    shown from its head. Byte decode is combinational, so the input side
//    takes one byte per cycle while the queue has space.
//  - Throughput: one byte per cycle while bytes cause at most one result
//    each and out_ready is high; overall the output port sets the pace at one
//    result per cycle, so an input causing N results needs N transfers.
//  - A bundle queue of QUEUE_DEPTH entries sits between lexer and output;
//    in_ready drops only when it is full, e.g. when the receiver stalls.
//  - Reset puts the lexer in the search state and empties the queue.
`default_nettype none

module markup_char_tokenizer #(
  parameter int QUEUE_DEPTH = mct_pkg::QUEUE_DEPTH_DEF  // 2 or more
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_input,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            item_kind,
  output logic [7:0]      token_char,
  output logic [4:0]      token_kind,
  output logic            last_of_run
);

  logic             space_ok;
  logic             push_valid;
  mct_pkg::bundle_t push_data;
  logic             head_valid;
  mct_pkg::bundle_t head_data;
  logic             pop;

  // Lexer: classify the byte and update the token state on each transfer.
  mct_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .space_ok     (space_ok),
    .push_valid   (push_valid),
    .push_data    (push_data)
  );

  // Hold result bundles so the lexer keeps going while the receiver stalls.
  mct_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .space_ok   (space_ok),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  // Serialize each bundle onto the output channel.
  mct_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_data   (head_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .item_kind   (item_kind),
    .token_char  (token_char),
    .token_kind  (token_kind),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

[src/mct_front.sv]
// Front end: accepts bytes, runs the lexer state, packs results per item.
// Depends on mct_pkg.
`default_nettype none

module mct_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_byte,
  input  wire logic             end_of_input,
  input  wire logic             space_ok,
  output logic                  push_valid,
  output mct_pkg::bundle_t      push_data
);

  mct_pkg::lex_state_t lex_state, lex_state_next;
  logic                dash_seen, dash_seen_next;

  logic                search_take, redo;
  mct_pkg::kind_t      redo_kind;
  logic [1:0]          s_cnt;
  mct_pkg::res_t [1:0] s_res;
  mct_pkg::lex_state_t s_state;
  mct_pkg::bundle_t    b;
  logic                accept;

  function automatic mct_pkg::res_t mk_char(input logic [7:0] c, input mct_pkg::kind_t k);
    mct_pkg::res_t r;
    r.item_kind  = mct_pkg::ITEM_CHAR;
    r.token_char = c;
    r.token_kind = k;
    return r;
  endfunction

  function automatic mct_pkg::res_t mk_end(input mct_pkg::kind_t k);
    mct_pkg::res_t r;
    r.item_kind  = mct_pkg::ITEM_END;
    r.token_char = 8'h00;
    r.token_kind = k;
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           (c == mct_pkg::CH_UNDER);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == mct_pkg::CH_SPACE) || (c == mct_pkg::CH_NL) || (c == mct_pkg::CH_TAB);
  endfunction

  function automatic mct_pkg::kind_t state_kind(input mct_pkg::lex_state_t s);
    mct_pkg::kind_t k;
    unique case (s)
      mct_pkg::ST_LT:     k = mct_pkg::K_LT;
      mct_pkg::ST_NAME:   k = mct_pkg::K_NAME;
      mct_pkg::ST_INT:    k = mct_pkg::K_INT;
      mct_pkg::ST_MINUS:  k = mct_pkg::K_MINUS;
      mct_pkg::ST_SLASH:  k = mct_pkg::K_SLASH;
      mct_pkg::ST_DEC:    k = mct_pkg::K_DEC;
      mct_pkg::ST_QUOTED: k = mct_pkg::K_QUOTED;
      mct_pkg::ST_BLANK:  k = mct_pkg::K_BLANK;
      mct_pkg::ST_QUEST:  k = mct_pkg::K_QUEST;
      mct_pkg::ST_COPEN:  k = mct_pkg::K_COPEN;
      mct_pkg::ST_CCLOSE: k = mct_pkg::K_CCLOSE;
      default:            k = mct_pkg::K_LT;
    endcase
    return k;
  endfunction

  // Search decode: what the byte starts when no token is open.
  always_comb begin
    s_cnt   = 2'd0;
    s_res   = '0;
    s_state = mct_pkg::ST_SEARCH;
    if (in_byte == mct_pkg::CH_LT) begin
      s_res[0] = mk_char(in_byte, mct_pkg::K_LT);
      s_cnt    = 2'd1;
      s_state  = mct_pkg::ST_LT;
    end else if (in_byte == mct_pkg::CH_GT) begin
      s_res[0] = mk_char(in_byte, mct_pkg::K_GT);
      s_res[1] = mk_end(mct_pkg::K_GT);
      s_cnt    = 2'd2;
    end else if (in_byte == mct_pkg::CH_EQ) begin
      s_res[0] = mk_char(in_byte, mct_pkg::K_EQ);
      s_res[1] = mk_end(mct_pkg::K_EQ);
      s_cnt    = 2'd2;
    end else if (is_alpha(in_byte)) begin
      s_res[0] = mk_char(in_byte, mct_pkg::K_NAME);
      s_cnt    = 2'd1;
      s_state  = mct_pkg::ST_NAME;
    end else if (is_digit(in_byte)) begin
      s_res[0] = mk_char(in_byte, mct_pkg::K_INT);
      s_cnt    = 2'd1;
      s_state  = mct_pkg::ST_INT;
    end else if (in_byte == mct_pkg::CH_DASH) begin
      s_res[0] = mk_char(in_byte, mct_pkg::K_MINUS);
      s_cnt    = 2'd1;
      s_state  = mct_pkg::ST_MINUS;
    end else if (in_byte == mct_pkg::CH_SLASH) begin
      s_res[0] = mk_char(in_byte, mct_pkg::K_SLASH);
      s_cnt    = 2'd1;
      s_state  = mct_pkg::ST_SLASH;
    end else if (in_byte == mct_pkg::CH_DOT) begin
      s_res[0] = mk_char(in_byte, mct_pkg::K_DEC);
      s_cnt    = 2'd1;
      s_state  = mct_pkg::ST_DEC;
    end else if (in_byte == mct_pkg::CH_QUOTE) begin
      s_state  = mct_pkg::ST_QUOTED;
    end else if (is_blank(in_byte)) begin
      s_res[0] = mk_char(in_byte, mct_pkg::K_BLANK);
      s_cnt    = 2'd1;
      s_state  = mct_pkg::ST_BLANK;
    end else if (in_byte == mct_pkg::CH_QUEST) begin
      s_res[0] = mk_char(in_byte, mct_pkg::K_QUEST);
      s_cnt    = 2'd1;
      s_state  = mct_pkg::ST_QUEST;
    end
  end

  // Next state and result bundle for one accepted item.
  always_comb begin
    b              = '0;
    lex_state_next = lex_state;
    dash_seen_next = dash_seen;
    search_take    = 1'b0;
    redo           = 1'b0;
    redo_kind      = mct_pkg::K_LT;
    if (end_of_input) begin
      lex_state_next = mct_pkg::ST_SEARCH;
      dash_seen_next = 1'b0;
      if (lex_state != mct_pkg::ST_SEARCH) begin
        b.res[0] = mk_end(state_kind(lex_state));
        b.cnt    = 2'd1;
      end
    end else begin
      unique case (lex_state)
        mct_pkg::ST_LT: begin
          if (in_byte == mct_pkg::CH_QUEST) begin
            b.res[0] = mk_char(in_byte, mct_pkg::K_HOPEN);
            b.res[1] = mk_end(mct_pkg::K_HOPEN);
            b.cnt    = 2'd2;
            lex_state_next = mct_pkg::ST_SEARCH;
          end else if (in_byte == mct_pkg::CH_SLASH) begin
            b.res[0] = mk_char(in_byte, mct_pkg::K_CLOPEN);
            b.res[1] = mk_end(mct_pkg::K_CLOPEN);
            b.cnt    = 2'd2;
            lex_state_next = mct_pkg::ST_SEARCH;
          end else if (in_byte == mct_pkg::CH_BANG) begin
            b.res[0] = mk_char(in_byte, mct_pkg::K_COPEN);
            b.cnt    = 2'd1;
            lex_state_next = mct_pkg::ST_COPEN;
            dash_seen_next = 1'b0;
          end else begin
            redo = 1'b1; redo_kind = mct_pkg::K_LT;
          end
        end
        mct_pkg::ST_NAME: begin
          if (is_alpha(in_byte) || is_digit(in_byte)) begin
            b.res[0] = mk_char(in_byte, mct_pkg::K_NAME);
            b.cnt    = 2'd1;
          end else begin
            redo = 1'b1; redo_kind = mct_pkg::K_NAME;
          end
        end
        mct_pkg::ST_INT: begin
          if (is_digit(in_byte)) begin
            b.res[0] = mk_char(in_byte, mct_pkg::K_INT);
            b.cnt    = 2'd1;
          end else if (in_byte == mct_pkg::CH_DOT) begin
            b.res[0] = mk_char(in_byte, mct_pkg::K_DEC);
            b.cnt    = 2'd1;
            lex_state_next = mct_pkg::ST_DEC;
          end else begin
            redo = 1'b1; redo_kind = mct_pkg::K_INT;
          end
        end
        mct_pkg::ST_DEC: begin
          if (is_digit(in_byte)) begin
            b.res[0] = mk_char(in_byte, mct_pkg::K_DEC);
            b.cnt    = 2'd1;
          end else begin
            redo = 1'b1; redo_kind = mct_pkg::K_DEC;
          end
        end
        mct_pkg::ST_MINUS: begin
          if (is_digit(in_byte)) begin
            b.res[0] = mk_char(in_byte, mct_pkg::K_INT);
            b.cnt    = 2'd1;
            lex_state_next = mct_pkg::ST_INT;
          end else if (in_byte == mct_pkg::CH_DOT) begin
            b.res[0] = mk_char(in_byte, mct_pkg::K_DEC);
            b.cnt    = 2'd1;
            lex_state_next = mct_pkg::ST_DEC;
          end else if (in_byte == mct_pkg::CH_DASH) begin
            b.res[0] = mk_char(in_byte, mct_pkg::K_CCLOSE);
            b.cnt    = 2'd1;
            lex_state_next = mct_pkg::ST_CCLOSE;
          end else begin
            redo = 1'b1; redo_kind = mct_pkg::K_MINUS;
          end
        end
        mct_pkg::ST_SLASH: begin
          if (in_byte == mct_pkg::CH_GT) begin
            b.res[0] = mk_char(in_byte, mct_pkg::K_ECLOSE);
            b.res[1] = mk_end(mct_pkg::K_ECLOSE);
            b.cnt    = 2'd2;
            lex_state_next = mct_pkg::ST_SEARCH;
          end else begin
            redo = 1'b1; redo_kind = mct_pkg::K_SLASH;
          end
        end
        mct_pkg::ST_QUOTED: begin
          if (in_byte == mct_pkg::CH_QUOTE) begin
            b.res[0] = mk_end(mct_pkg::K_QUOTED);
            b.cnt    = 2'd1;
            lex_state_next = mct_pkg::ST_SEARCH;
          end else begin
            b.res[0] = mk_char(in_byte, mct_pkg::K_QUOTED);
            b.cnt    = 2'd1;
          end
        end
        mct_pkg::ST_BLANK: begin
          if (is_blank(in_byte)) begin
            b.res[0] = mk_char(in_byte, mct_pkg::K_BLANK);
            b.cnt    = 2'd1;
          end else begin
            redo = 1'b1; redo_kind = mct_pkg::K_BLANK;
          end
        end
        mct_pkg::ST_QUEST: begin
          if (in_byte == mct_pkg::CH_GT) begin
            b.res[0] = mk_char(in_byte, mct_pkg::K_HCLOSE);
            b.res[1] = mk_end(mct_pkg::K_HCLOSE);
            b.cnt    = 2'd2;
            lex_state_next = mct_pkg::ST_SEARCH;
          end else begin
            redo = 1'b1; redo_kind = mct_pkg::K_QUEST;
          end
        end
        mct_pkg::ST_COPEN: begin
          if (in_byte == mct_pkg::CH_DASH) begin
            b.res[0] = mk_char(in_byte, mct_pkg::K_COPEN);
            if (dash_seen) begin
              b.res[1] = mk_end(mct_pkg::K_COPEN);
              b.cnt    = 2'd2;
              lex_state_next = mct_pkg::ST_SEARCH;
              dash_seen_next = 1'b0;
            end else begin
              b.cnt    = 2'd1;
              dash_seen_next = 1'b1;
            end
          end else begin
            redo = 1'b1; redo_kind = mct_pkg::K_ERROR;
          end
        end
        mct_pkg::ST_CCLOSE: begin
          if (in_byte == mct_pkg::CH_GT) begin
            b.res[0] = mk_char(in_byte, mct_pkg::K_CCLOSE);
            b.res[1] = mk_end(mct_pkg::K_CCLOSE);
            b.cnt    = 2'd2;
            lex_state_next = mct_pkg::ST_SEARCH;
          end else begin
            redo = 1'b1; redo_kind = mct_pkg::K_ERROR;
          end
        end
        default: begin
          search_take = 1'b1;
        end
      endcase

      // Close the open token, then handle the same byte from search.
      if (redo) begin
        b.res[0] = mk_end(redo_kind);
        b.res[1] = s_res[0];
        b.res[2] = s_res[1];
        b.cnt    = 2'd1 + s_cnt;
        lex_state_next = s_state;
        dash_seen_next = 1'b0;
      end else if (search_take) begin
        b.res[0] = s_res[0];
        b.res[1] = s_res[1];
        b.cnt    = s_cnt;
        lex_state_next = s_state;
        dash_seen_next = 1'b0;
      end
    end
  end

  assign in_ready   = space_ok;
  assign accept     = in_valid && space_ok;
  assign push_valid = accept && (b.cnt != 2'd0);
  assign push_data  = b;

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_state <= mct_pkg::ST_SEARCH;
      dash_seen <= 1'b0;
    end else if (accept) begin
      lex_state <= lex_state_next;
      dash_seen <= dash_seen_next;
    end
  end

endmodule

`default_nettype wire

[src/mct_queue.sv]
// Short queue of result bundles between front and back end.
// Depends on mct_pkg.
`default_nettype none

module mct_queue #(
  parameter int QUEUE_DEPTH = mct_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  input  wire mct_pkg::bundle_t push_data,
  output logic                  space_ok,
  output logic                  head_valid,
  output mct_pkg::bundle_t      head_data,
  input  wire logic             pop
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  mct_pkg::bundle_t mem [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  count;
  logic             push_fire, pop_fire;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign space_ok   = (count != CntW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];
  assign push_fire  = push_valid && space_ok;
  assign pop_fire   = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) wr_ptr <= ptr_inc(wr_ptr);
      if (pop_fire)  rd_ptr <= ptr_inc(rd_ptr);
      if (push_fire && !pop_fire)      count <= count + 1'b1;
      else if (pop_fire && !push_fire) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) mem[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

[src/mct_back.sv]
// Back end: hands out the results of the head bundle one per transfer.
// Depends on mct_pkg.
`default_nettype none

module mct_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  wire mct_pkg::bundle_t head_data,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  item_kind,
  output logic [7:0]            token_char,
  output logic [4:0]            token_kind,
  output logic                  last_of_run
);

  logic [1:0]    idx;
  mct_pkg::res_t cur;
  logic          fire;

  assign cur         = head_data.res[idx];
  assign out_valid   = head_valid;
  assign item_kind   = cur.item_kind;
  assign token_char  = cur.token_char;
  assign token_kind  = cur.token_kind;
  assign last_of_run = (idx == head_data.cnt - 2'd1);
  assign fire        = out_valid && out_ready;
  assign pop         = fire && last_of_run;

  // Advance through the bundle; drop it after its last result.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (fire) begin
      idx <= last_of_run ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

[src/mct_checker.sv]
// Port-level checks of the markup character tokenizer, bound to its top.
// Depends on assert_macros.svh and mct_pkg.
`default_nettype none
`include "assert_macros.svh"

module mct_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       item_kind,
  input wire logic [7:0] token_char,
  input wire logic [4:0] token_kind,
  input wire logic       last_of_run
);

  `MCT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(token_char) && $stable(token_kind) && $stable(item_kind) && $stable(last_of_run), "output changed while stalled")
  `MCT_ASSERT_NOW(a_end_char_zero, clk, rst, out_valid && (item_kind == mct_pkg::ITEM_END), token_char == 8'h00, "end item carries a character")
  `MCT_ASSERT_NOW(a_kind_range, clk, rst, out_valid, token_kind <= 5'(mct_pkg::K_ERROR), "token kind out of range")
  `MCT_ASSERT_NOW(a_char_not_error, clk, rst, out_valid && (item_kind == mct_pkg::ITEM_CHAR), token_kind != 5'(mct_pkg::K_ERROR), "character item of error kind")

endmodule

bind markup_char_tokenizer mct_checker u_mct_checker (.*);

`default_nettype wire

[dv/markup_char_tokenizer_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for markup_char_tokenizer: byte stream in, token results out.
// Depends on mct_pkg for state and token kind codes; a scoreboard class predicts results.

module markup_char_tokenizer_tb;

  localparam int RANDOM_ITEMS    = 366;
  localparam int HOLD_OFF_CYCLES = 150;  // long receiver stall to fill the bundle queue
  localparam int TAIL_CYCLES     = 20;

  // One input transfer: a text byte, or the end-of-text marker.
  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
  } text_item_t;

  // One expected result, including the end-of-run flag.
  typedef struct packed {
    logic           ik;
    logic [7:0]     ch;
    mct_pkg::kind_t tk;
    logic           last;
  } tok_result_t;

  // Predicts the token stream byte by byte and checks each output transfer
  // against the oldest pending prediction.
  class token_scoreboard;
    mct_pkg::lex_state_t state;
    logic [2:0]          dashes;
    tok_result_t         step_q[$];
    tok_result_t         expected_q[$];
    int                  mismatches;
    int                  inputs_seen;
    int                  results_checked;
    logic [17:0]         kinds_closed;

    function new();
      state           = mct_pkg::ST_SEARCH;
      dashes          = 3'd0;
      mismatches      = 0;
      inputs_seen     = 0;
      results_checked = 0;
      kinds_closed    = '0;
    endfunction

    task report(string msg);
      $display("[%0t] ERROR: %s", $realtime, msg);
      mismatches++;
    endtask

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == mct_pkg::CH_UNDER;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == mct_pkg::CH_SPACE || c == mct_pkg::CH_NL || c == mct_pkg::CH_TAB;
    endfunction

    // Kind reported when a partial token is closed by end of text.
    function mct_pkg::kind_t kind_of(mct_pkg::lex_state_t s);
      case (s)
        mct_pkg::ST_LT:     return mct_pkg::K_LT;
        mct_pkg::ST_NAME:   return mct_pkg::K_NAME;
        mct_pkg::ST_INT:    return mct_pkg::K_INT;
        mct_pkg::ST_MINUS:  return mct_pkg::K_MINUS;
        mct_pkg::ST_SLASH:  return mct_pkg::K_SLASH;
        mct_pkg::ST_DEC:    return mct_pkg::K_DEC;
        mct_pkg::ST_QUOTED: return mct_pkg::K_QUOTED;
        mct_pkg::ST_BLANK:  return mct_pkg::K_BLANK;
        mct_pkg::ST_QUEST:  return mct_pkg::K_QUEST;
        mct_pkg::ST_COPEN:  return mct_pkg::K_COPEN;
        mct_pkg::ST_CCLOSE: return mct_pkg::K_CCLOSE;
        default:            return mct_pkg::K_LT;
      endcase
    endfunction

    function void emit(logic ik, logic [7:0] ch, mct_pkg::kind_t k);
      tok_result_t r;
      if (step_q.size() >= 3) return;
      r.ik   = ik;
      r.ch   = ch;
      r.tk   = k;
      r.last = 1'b0;
      step_q.push_back(r);
    endfunction

    function void close_token(mct_pkg::kind_t k);
      emit(mct_pkg::ITEM_END, 8'h00, k);
      state  = mct_pkg::ST_SEARCH;
      dashes = 3'd0;
    endfunction

    function void start_token(logic [7:0] c);
      state  = mct_pkg::ST_SEARCH;
      dashes = 3'd0;
      if (c == mct_pkg::CH_LT) begin
        emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_LT); state = mct_pkg::ST_LT;
      end else if (c == mct_pkg::CH_GT) begin
        emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_GT); close_token(mct_pkg::K_GT);
      end else if (c == mct_pkg::CH_EQ) begin
        emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_EQ); close_token(mct_pkg::K_EQ);
      end else if (is_alpha(c)) begin
        emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_NAME); state = mct_pkg::ST_NAME;
      end else if (is_digit(c)) begin
        emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_INT); state = mct_pkg::ST_INT;
      end else if (c == mct_pkg::CH_DASH) begin
        emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_MINUS); state = mct_pkg::ST_MINUS;
      end else if (c == mct_pkg::CH_SLASH) begin
        emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_SLASH); state = mct_pkg::ST_SLASH;
      end else if (c == mct_pkg::CH_DOT) begin
        emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_DEC); state = mct_pkg::ST_DEC;
      end else if (c == mct_pkg::CH_QUOTE) begin
        state = mct_pkg::ST_QUOTED;
      end else if (is_blank(c)) begin
        emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_BLANK); state = mct_pkg::ST_BLANK;
      end else if (c == mct_pkg::CH_QUEST) begin
        emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_QUEST); state = mct_pkg::ST_QUEST;
      end
    endfunction

    // Byte that does not fit: close the token, then reprocess from search.
    function void close_and_restart(mct_pkg::kind_t k, logic [7:0] c);
      close_token(k);
      start_token(c);
    endfunction

    function void lex_byte(logic [7:0] c);
      case (state)
        mct_pkg::ST_LT: begin
          if (c == mct_pkg::CH_QUEST) begin
            emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_HOPEN); close_token(mct_pkg::K_HOPEN);
          end else if (c == mct_pkg::CH_SLASH) begin
            emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_CLOPEN); close_token(mct_pkg::K_CLOPEN);
          end else if (c == mct_pkg::CH_BANG) begin
            emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_COPEN);
            state  = mct_pkg::ST_COPEN;
            dashes = 3'd0;
          end else close_and_restart(mct_pkg::K_LT, c);
        end
        mct_pkg::ST_NAME: begin
          if (is_alpha(c) || is_digit(c)) emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_NAME);
          else close_and_restart(mct_pkg::K_NAME, c);
        end
        mct_pkg::ST_INT: begin
          if (is_digit(c)) emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_INT);
          else if (c == mct_pkg::CH_DOT) begin
            emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_DEC); state = mct_pkg::ST_DEC;
          end else close_and_restart(mct_pkg::K_INT, c);
        end
        mct_pkg::ST_DEC: begin
          if (is_digit(c)) emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_DEC);
          else close_and_restart(mct_pkg::K_DEC, c);
        end
        mct_pkg::ST_MINUS: begin
          if (is_digit(c)) begin
            emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_INT); state = mct_pkg::ST_INT;
          end else if (c == mct_pkg::CH_DOT) begin
            emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_DEC); state = mct_pkg::ST_DEC;
          end else if (c == mct_pkg::CH_DASH) begin
            emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_CCLOSE); state = mct_pkg::ST_CCLOSE;
          end else close_and_restart(mct_pkg::K_MINUS, c);
        end
        mct_pkg::ST_SLASH: begin
          if (c == mct_pkg::CH_GT) begin
            emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_ECLOSE); close_token(mct_pkg::K_ECLOSE);
          end else close_and_restart(mct_pkg::K_SLASH, c);
        end
        mct_pkg::ST_QUOTED: begin
          if (c == mct_pkg::CH_QUOTE) close_token(mct_pkg::K_QUOTED);
          else emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_QUOTED);
        end
        mct_pkg::ST_BLANK: begin
          if (is_blank(c)) emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_BLANK);
          else close_and_restart(mct_pkg::K_BLANK, c);
        end
        mct_pkg::ST_QUEST: begin
          if (c == mct_pkg::CH_GT) begin
            emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_HCLOSE); close_token(mct_pkg::K_HCLOSE);
          end else close_and_restart(mct_pkg::K_QUEST, c);
        end
        mct_pkg::ST_COPEN: begin
          if (c == mct_pkg::CH_DASH) begin
            emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_COPEN);
            if (dashes < 3'd7) dashes = dashes + 3'd1;
            if (dashes >= 3'd2) close_token(mct_pkg::K_COPEN);
          end else close_and_restart(mct_pkg::K_ERROR, c);
        end
        mct_pkg::ST_CCLOSE: begin
          if (c == mct_pkg::CH_GT) begin
            emit(mct_pkg::ITEM_CHAR, c, mct_pkg::K_CCLOSE); close_token(mct_pkg::K_CCLOSE);
          end else close_and_restart(mct_pkg::K_ERROR, c);
        end
        default: start_token(c);
      endcase
    endfunction

    // Record one accepted input transfer and queue the results it causes.
    function void note_input(logic [7:0] c, logic eoi);
      step_q.delete();
      inputs_seen++;
      if (eoi) begin
        if (state != mct_pkg::ST_SEARCH) close_token(kind_of(state));
        state  = mct_pkg::ST_SEARCH;
        dashes = 3'd0;
      end else begin
        lex_byte(c);
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    endfunction

    task check_result(logic ik, logic [7:0] ch, logic [4:0] tk, logic last);
      tok_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result item_kind=%0b char=%02h kind=%0d last=%0b",
                         ik, ch, tk, last));
        return;
      end
      e = expected_q.pop_front();
      results_checked++;
      if (ik !== e.ik)
        report($sformatf("result %0d item_kind got %0b want %0b", results_checked, ik, e.ik));
      if (ch !== e.ch)
        report($sformatf("result %0d token_char got %02h want %02h",
                         results_checked, ch, e.ch));
      if (tk !== e.tk)
        report($sformatf("result %0d token_kind got %0d want %0d (%s)",
                         results_checked, tk, e.tk, e.tk.name()));
      if (last !== e.last)
        report($sformatf("result %0d last_of_run got %0b want %0b",
                         results_checked, last, e.last));
      if (e.ik == mct_pkg::ITEM_END) kinds_closed[e.tk] = 1'b1;
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       end_of_input;
  logic       out_valid;
  logic       out_ready;
  logic       item_kind;
  logic [7:0] token_char;
  logic [4:0] token_kind;
  logic       last_of_run;

  token_scoreboard sb;
  text_item_t      text_q[$];
  int              items_sent;
  int              results_seen;
  bit              send_burst;
  bit              recv_burst;

  // Fixed markup fragments for the well-formed part of the random text.
  string markup_pieces[12] = '{"<", ">", "=", "<?", "?>", "</", "/>", "<!--", "-->",
                               "?", "/", "<!---->"};

  markup_char_tokenizer dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .end_of_input(end_of_input),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .item_kind   (item_kind),
    .token_char  (token_char),
    .token_kind  (token_kind),
    .last_of_run (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #2_000_000;
    $display("Timed out with %0d inputs sent and %0d results seen", items_sent, results_seen);
    $display("Mismatches found");
    $finish;
  end

  task push_byte(logic [7:0] b, logic eoi);
    text_item_t t;
    t.b   = b;
    t.eoi = eoi;
    text_q.push_back(t);
  endtask

  task push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  function logic [7:0] rand_letter();
    int idx;
    idx = $urandom_range(0, 52);
    if (idx < 26) return 8'h41 + 8'(idx);
    if (idx < 52) return 8'h61 + 8'(idx - 26);
    return mct_pkg::CH_UNDER;
  endfunction

  function logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  // Append one token's worth of text; mostly well-formed, the rest broken
  // comment delimiters, raw noise bytes and end-of-text markers.
  task gen_token();
    logic [7:0] b;
    int         n;
    case ($urandom_range(0, 9))
      0, 1: begin
        push_byte(rand_letter(), 1'b0);
        n = $urandom_range(0, 5);
        repeat (n) push_byte($urandom_range(0, 2) == 0 ? rand_digit() : rand_letter(), 1'b0);
      end
      2: begin
        if ($urandom_range(0, 1)) push_byte(mct_pkg::CH_DASH, 1'b0);
        n = $urandom_range(0, 4);
        repeat (n) push_byte(rand_digit(), 1'b0);
        if ($urandom_range(0, 1)) begin
          push_byte(mct_pkg::CH_DOT, 1'b0);
          n = $urandom_range(0, 3);
          repeat (n) push_byte(rand_digit(), 1'b0);
        end
      end
      3: begin
        push_byte(mct_pkg::CH_QUOTE, 1'b0);
        n = $urandom_range(0, 5);
        repeat (n) begin
          b = 8'($urandom_range(0, 255));
          if (b == mct_pkg::CH_QUOTE) b = b ^ 8'h01;
          push_byte(b, 1'b0);
        end
        // Occasionally leave the string open so later text lands inside it.
        if ($urandom_range(0, 7) != 0) push_byte(mct_pkg::CH_QUOTE, 1'b0);
      end
      4: begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          case ($urandom_range(0, 2))
            0: push_byte(mct_pkg::CH_SPACE, 1'b0);
            1: push_byte(mct_pkg::CH_NL, 1'b0);
            default: push_byte(mct_pkg::CH_TAB, 1'b0);
          endcase
        end
      end
      5, 6: push_text(markup_pieces[$urandom_range(0, 11)]);
      7: begin
        case ($urandom_range(0, 2))
          0: push_text("<!");
          1: push_text("<!-");
          default: push_text("--");
        endcase
        push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      8: begin
        n = $urandom_range(1, 3);
        repeat (n) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      default: push_byte(8'($urandom_range(0, 255)), 1'b1);
    endcase
  endtask

  // Offer one item after a random gap and hold it until the transfer.
  task send_item(text_item_t t);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 59) == 0) send_burst = !send_burst;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= t.b;
    end_of_input <= t.eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(t.b, t.eoi);
    items_sent++;
  endtask

  // Accept results with random stalls; twice, stall long enough that the
  // queue inside the block fills and in_ready drops.
  task drain_results();
    int gap;
    forever begin
      if (results_seen == 60 || results_seen == 300) gap = HOLD_OFF_CYCLES;
      else gap = recv_burst ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 59) == 0) recv_burst = !recv_burst;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(item_kind, token_char, token_kind, last_of_run);
      results_seen++;
    end
  endtask

  initial begin
    int total_items;
    sb           = new();
    items_sent   = 0;
    results_seen = 0;
    send_burst   = 1'b0;
    recv_burst   = 1'b0;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    in_byte      <= 8'h00;
    end_of_input <= 1'b0;
    out_ready    <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed text: every token kind but LT, GT, MINUS, SLASH and QUEST, both
    // bad comment openers, a bad closer, a quoted run holding the byte extremes,
    // and end of text in the middle of a token, in a partial opener and in search.
    push_text("<?x=-1.5?>");
    push_text("<!---->");
    push_byte(mct_pkg::CH_QUOTE, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(mct_pkg::CH_QUOTE, 1'b0);
    push_text(" \t\n</");
    push_text("<!x--a/>");
    push_text("<!-7");
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_text("<!-");
    push_byte(8'h5A, 1'b1);
    total_items = text_q.size() + RANDOM_ITEMS;

    fork
      drain_results();
    join_none

    while (items_sent < total_items) begin
      if (text_q.size() == 0) gen_token();
      send_item(text_q.pop_front());
    end
    in_valid <= 1'b0;

    // Drain, then wait out the tail for any stray result.
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d input transfers and checked %0d results", sb.inputs_seen,
             sb.results_checked);
    $display("Token kinds closed: %0d of 18", $countones(sb.kinds_closed));
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/mct_pkg.sv
src/mct_front.sv
src/mct_queue.sv
src/mct_back.sv
src/markup_char_tokenizer.sv
src/mct_checker.sv
dv/markup_char_tokenizer_tb.sv
